FILE: design/wdtw_pkg.sv
// ----------------------------------------------------------------------------
// wdtw_pkg
// Shared widths, reset values, register indexes and types for the weighted
// time warping cell update unit.
// ----------------------------------------------------------------------------
package wdtw_pkg;

    localparam int unsigned MAX_REF_DEF = 1024;

    localparam int COST_W = 32;     // accumulated cost, Q24.8
    localparam int LC_W   = 16;     // local cost, Q8.8
    localparam int WGT_W  = 8;      // step weight, Q4.4
    localparam int LEN_W  = 11;     // ref_length register
    localparam int PROD_W = LC_W + WGT_W;
    localparam int TERM_W = PROD_W - 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [COST_W-1:0] INF_COST = '1;

    localparam logic [LEN_W-1:0] REF_LENGTH_RST = 11'd1024;
    localparam logic [WGT_W-1:0] WEIGHT_RST     = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LENGTH   = 2'd0,
        CFG_WEIGHT_DIAG  = 2'd1,
        CFG_WEIGHT_LEFT  = 2'd2,
        CFG_WEIGHT_ABOVE = 2'd3
    } t_cfg_idx;

    // Operands of one cell: the three neighbors and their weighted terms.
    typedef struct packed {
        logic [COST_W-1:0] above;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
        logic [TERM_W-1:0] term_above;
        logic [TERM_W-1:0] term_left;
        logic [TERM_W-1:0] term_diag;
    } t_cell_ops;

endpackage

FILE: design/weighted_dtw_cell_update_unit.sv
// ----------------------------------------------------------------------------
// weighted_dtw_cell_update_unit
// Weighted time warping grid: one accumulated cost per local cost beat.
// ----------------------------------------------------------------------------
// Usage:
//   Feed local costs in row-major order on the input channel (i_in_valid /
//   o_in_ready), one beat per grid cell; set i_new_match on the first cell
//   of an alignment. Each beat yields one result beat on the output channel
//   (o_out_valid / i_out_ready) carrying the accumulated cost and a row_end
//   flag on the last column of each row.
//   Throughput is one beat per cycle while i_out_ready stays high: the
//   previous-row memory is read at accept and written as the cell leaves the
//   compute stage, so every cell costs one read and one write on its two
//   ports. A beat passes the compute stage, then the output register.
//   The running left and diagonal values live in registers; a write to the
//   entry being read in the same cycle is forwarded from the compute stage.
//   A stalled receiver holds the output register; the compute stage still
//   takes one more beat, then o_in_ready drops until the output drains.
//   Reset restores the configuration defaults, empties the pipeline and
//   starts a fresh alignment at row zero, column zero. The row memory needs
//   no clearing: row zero ignores the data it reads.
//   Write configuration through i_cfg_we / i_cfg_index / i_cfg_data only
//   while the unit is idle.
// ----------------------------------------------------------------------------
module weighted_dtw_cell_update_unit #(
    parameter int MAX_REF = wdtw_pkg::MAX_REF_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [wdtw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wdtw_pkg::LEN_W-1:0]    i_cfg_data,
    // local cost channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wdtw_pkg::LC_W-1:0]     i_local_cost,
    input  logic                          i_new_match,
    // accumulated cost channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wdtw_pkg::COST_W-1:0]   o_accumulated_cost,
    output logic                          o_row_end
);
    import wdtw_pkg::*;

    localparam int AW  = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
    localparam int LW0 = $clog2(MAX_REF + 1);
    localparam int LW  = (LW0 > LEN_W) ? LW0 : LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_REF);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] r_ref_length;
    logic [WGT_W-1:0] r_weight_diag;
    logic [WGT_W-1:0] r_weight_left;
    logic [WGT_W-1:0] r_weight_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_length   <= REF_LENGTH_RST;
            r_weight_diag  <= WEIGHT_RST;
            r_weight_left  <= WEIGHT_RST;
            r_weight_above <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REF_LENGTH:   r_ref_length   <= i_cfg_data;
                CFG_WEIGHT_DIAG:  r_weight_diag  <= i_cfg_data[WGT_W-1:0];
                CFG_WEIGHT_LEFT:  r_weight_left  <= i_cfg_data[WGT_W-1:0];
                CFG_WEIGHT_ABOVE: r_weight_above <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_move;
    logic w_accept;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Accept stage: column bookkeeping, memory read, weighted terms
    // ------------------------------------------------------------------
    logic [AW-1:0] r_col;
    logic          r_first_row;

    logic [LW-1:0] w_len_raw;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_last_idx;
    logic [AW-1:0] w_col;
    logic          w_first;
    logic          w_last;

    // Clamp the row length into 1..MAX_REF.
    assign w_len_raw  = LW'(r_ref_length);
    assign w_len      = (w_len_raw == '0) ? LW'(1) :
                        ((w_len_raw > MAX_LEN) ? MAX_LEN : w_len_raw);
    assign w_last_idx = w_len - LW'(1);

    // A new alignment restarts at column zero of row zero.
    assign w_col   = i_new_match ? '0 : r_col;
    assign w_first = i_new_match ? 1'b1 : r_first_row;
    assign w_last  = LW'(w_col) >= w_last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (w_accept) begin
            r_col       <= w_last ? '0 : w_col + AW'(1);
            r_first_row <= w_last ? 1'b0 : w_first;
        end
    end

    function automatic logic [TERM_W-1:0] f_term(
        input logic [WGT_W-1:0] weight,
        input logic [LC_W-1:0]  cost
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(weight) * PROD_W'(cost);
        // Q12.12 to Q12.8 with round half up; cannot overflow PROD_W.
        return TERM_W'((prod + PROD_W'(8)) >> 4);
    endfunction

    // ------------------------------------------------------------------
    // Compute stage registers
    // ------------------------------------------------------------------
    logic [AW-1:0]     r_s1_addr;
    logic              r_s1_first;
    logic              r_s1_start;
    logic              r_s1_last;
    logic [TERM_W-1:0] r_s1_term_above;
    logic [TERM_W-1:0] r_s1_term_left;
    logic [TERM_W-1:0] r_s1_term_diag;
    logic              r_fwd_hit;
    logic [COST_W-1:0] r_fwd_data;

    logic [COST_W-1:0] w_best;
    logic [COST_W-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr       <= w_col;
            r_s1_first      <= w_first;
            r_s1_start      <= i_new_match;
            r_s1_last       <= w_last;
            r_s1_term_above <= f_term(r_weight_above, i_local_cost);
            r_s1_term_left  <= f_term(r_weight_left,  i_local_cost);
            r_s1_term_diag  <= f_term(r_weight_diag,  i_local_cost);
            // The memory returns the old entry if the cell ahead writes it now.
            r_fwd_hit       <= w_s1_move && (r_s1_addr == w_col);
            r_fwd_data      <= w_best;
        end
    end

    // ------------------------------------------------------------------
    // Previous-row memory
    // ------------------------------------------------------------------
    wdtw_row_mem #(
        .DEPTH (MAX_REF),
        .AW    (AW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_s1_move),
        .i_waddr (r_s1_addr),
        .i_wdata (w_best),
        .i_re    (w_accept),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Compute stage: neighbors, weighted minimum, running left / diagonal
    // ------------------------------------------------------------------
    logic [COST_W-1:0] r_left;
    logic [COST_W-1:0] r_diag;
    logic [COST_W-1:0] w_above;
    t_cell_ops         w_ops;

    // Row zero sees infinity above and ignores the memory read data.
    assign w_above = r_s1_first ? INF_COST : (r_fwd_hit ? r_fwd_data : w_rdata);

    assign w_ops.above      = w_above;
    assign w_ops.left       = r_s1_start ? INF_COST : r_left;
    assign w_ops.diag       = r_s1_start ? '0 : r_diag;
    assign w_ops.term_above = r_s1_term_above;
    assign w_ops.term_left  = r_s1_term_left;
    assign w_ops.term_diag  = r_s1_term_diag;

    wdtw_cell_calc u_cell_calc (
        .i_ops  (w_ops),
        .o_best (w_best)
    );

    // After the last column both neighbors fall on column zero: infinity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= INF_COST;
            r_diag <= '0;
        end else if (w_s1_move) begin
            r_left <= r_s1_last ? INF_COST : w_best;
            r_diag <= r_s1_last ? INF_COST : w_above;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [COST_W-1:0] r_out_cost;
    logic              r_out_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_cost    <= w_best;
            r_out_row_end <= r_s1_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accumulated_cost = r_out_cost;
    assign o_row_end          = r_out_row_end;

endmodule

FILE: design/wdtw_row_mem.sv
// ----------------------------------------------------------------------------
// wdtw_row_mem
// Previous-row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wdtw_row_mem #(
    parameter int DEPTH = wdtw_pkg::MAX_REF_DEF,
    parameter int AW    = $clog2(wdtw_pkg::MAX_REF_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [wdtw_pkg::COST_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [wdtw_pkg::COST_W-1:0] o_rdata
);
    import wdtw_pkg::*;

    logic [COST_W-1:0] r_mem [DEPTH];
    logic [COST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the old entry when the same address is written this edge.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/wdtw_cell_calc.sv
// ----------------------------------------------------------------------------
// wdtw_cell_calc
// Saturating weighted adds for the three neighbors and the minimum of them.
// ----------------------------------------------------------------------------
module wdtw_cell_calc (
    input  wdtw_pkg::t_cell_ops         i_ops,
    output logic [wdtw_pkg::COST_W-1:0] o_best
);
    import wdtw_pkg::*;

    function automatic logic [COST_W-1:0] f_sat_add(
        input logic [COST_W-1:0] base,
        input logic [TERM_W-1:0] term
    );
        logic [COST_W:0] sum;
        sum = {1'b0, base} + (COST_W+1)'(term);
        return sum[COST_W] ? INF_COST : sum[COST_W-1:0];
    endfunction

    logic [COST_W-1:0] w_c_above;
    logic [COST_W-1:0] w_c_left;
    logic [COST_W-1:0] w_c_diag;
    logic [COST_W-1:0] w_min_al;

    assign w_c_above = f_sat_add(i_ops.above, i_ops.term_above);
    assign w_c_left  = f_sat_add(i_ops.left,  i_ops.term_left);
    assign w_c_diag  = f_sat_add(i_ops.diag,  i_ops.term_diag);

    // Ties keep the earlier candidate: above, then left, then diagonal.
    assign w_min_al = (w_c_left < w_c_above) ? w_c_left : w_c_above;
    assign o_best   = (w_c_diag < w_min_al) ? w_c_diag : w_min_al;

endmodule
